// ===== design/dpq_pkg.sv =====
package dpq_pkg;

    // Request opcodes
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DEL_MAX = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;
    localparam logic [1:0] OP_PEEK    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Per-cycle action of a row of cells
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_SHIFT  = 2'd2;

    typedef struct packed {
        logic signed [15:0] prio;
        logic [15:0]        data;
    } word_t;

    typedef struct packed {
        logic [1:0] op;
        word_t      new_word;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] entry_priority;
        logic [15:0]        entry_data;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] removed_priority;
        logic [15:0]        removed_data;
        logic signed [15:0] top_priority;
        logic [15:0]        top_data;
        logic signed [15:0] bottom_priority;
        logic [15:0]        bottom_data;
        logic [4:0]         entry_count;
    } rsp_t;

endpackage

// ===== design/double_ended_priority_queue.sv =====
// Channel   Ports                 Handshake
// request   start, busy, request  taken when start is high and busy is low
// result    done, result          shown for one cycle while done is high
//
// One request completes per cycle; its result appears on the cycle after it
// is taken. Two rows of cells hold the entries, one ordered from the highest
// priority and one from the lowest, so both ends are always at cell 0 and
// every operation is a single parallel compare and shift. busy stays low.
// Reset empties the queue; cell contents are left as they are. The receiver
// cannot stall the result.
module double_ended_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  dpq_pkg::req_t  request,
    output logic           done,
    output dpq_pkg::rsp_t  result
);
    import dpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    rsp_t             result_reg;
    rsp_t             result_next;

    cell_ctrl_t       hi_ctrl;
    cell_ctrl_t       lo_ctrl;
    word_t            hi_head;
    word_t            hi_head_next;
    word_t            lo_head;
    word_t            lo_head_next;
    word_t            removed;
    logic [1:0]       status;
    logic             accept;
    logic             is_full;
    logic             is_empty;

    assign accept   = start && !busy;
    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;

    // Decode the request into row actions
    always_comb
    begin
        hi_ctrl.op       = CELL_HOLD;
        lo_ctrl.op       = CELL_HOLD;
        hi_ctrl.new_word = '{prio: request.entry_priority, data: request.entry_data};
        lo_ctrl.new_word = hi_ctrl.new_word;
        count_next       = count_reg;
        status           = ST_OK;
        removed          = '0;
        if (accept)
        begin
            unique case (request.opcode)
                OP_INSERT:
                begin
                    if (is_full)
                        status = ST_FULL;
                    else
                    begin
                        hi_ctrl.op = CELL_INSERT;
                        lo_ctrl.op = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DEL_MAX:
                begin
                    if (is_empty)
                        status = ST_EMPTY;
                    else
                    begin
                        hi_ctrl.op = CELL_SHIFT;
                        removed    = hi_head;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_DEL_MIN:
                begin
                    if (is_empty)
                        status = ST_EMPTY;
                    else
                    begin
                        lo_ctrl.op = CELL_SHIFT;
                        removed    = lo_head;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                    status = ST_OK;
            endcase
        end
    end

    dpq_row #(
        .CAPACITY   (CAPACITY),
        .CNT_W      (CNT_W),
        .DESCENDING (1'b1)
    ) u_hi_row (
        .clk       (clk),
        .ctrl      (hi_ctrl),
        .count     (count_reg),
        .head      (hi_head),
        .head_next (hi_head_next)
    );

    dpq_row #(
        .CAPACITY   (CAPACITY),
        .CNT_W      (CNT_W),
        .DESCENDING (1'b0)
    ) u_lo_row (
        .clk       (clk),
        .ctrl      (lo_ctrl),
        .count     (count_reg),
        .head      (lo_head),
        .head_next (lo_head_next)
    );

    // Assemble the result from the state after this step
    always_comb
    begin
        result_next.status           = status;
        result_next.removed_priority = removed.prio;
        result_next.removed_data     = removed.data;
        result_next.entry_count      = 5'(count_next);
        if (count_next == '0)
        begin
            result_next.top_priority    = '0;
            result_next.top_data        = '0;
            result_next.bottom_priority = '0;
            result_next.bottom_data     = '0;
        end
        else
        begin
            result_next.top_priority    = hi_head_next.prio;
            result_next.top_data        = hi_head_next.data;
            result_next.bottom_priority = lo_head_next.prio;
            result_next.bottom_data     = lo_head_next.data;
        end
    end

    // Advance the count and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Register the result of each accepted request; it holds until the next one
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    // Every request is handled in a single parallel step, so nothing holds requests off
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/dpq_cell.sv =====
module dpq_cell #(
    parameter int IDX        = 0,
    parameter int CNT_W      = 5,
    parameter bit DESCENDING = 1'b1
) (
    input  logic               clk,
    input  dpq_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   count,
    input  dpq_pkg::word_t     left_word,
    input  logic               left_keep,
    input  dpq_pkg::word_t     right_word,
    output dpq_pkg::word_t     word,
    output dpq_pkg::word_t     word_next,
    output logic               keep
);
    import dpq_pkg::*;

    word_t word_reg;
    logic  occupied;
    logic  stays_ahead;

    // Decide whether this entry stays ahead of the new one
    assign occupied = CNT_W'(IDX) < count;
    assign stays_ahead = DESCENDING ? (word_reg.prio > ctrl.new_word.prio)
                                    : (word_reg.prio <= ctrl.new_word.prio);
    assign keep = occupied && stays_ahead;

    // Hold, take the new entry, take the left neighbour or take the right one
    always_comb
    begin
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (keep)
                    word_next = word_reg;
                else if (IDX == 0 || left_keep)
                    word_next = ctrl.new_word;
                else
                    word_next = left_word;
            end
            CELL_SHIFT:
                word_next = right_word;
            default:
                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== design/dpq_row.sv =====
module dpq_row #(
    parameter int CAPACITY   = 16,
    parameter int CNT_W      = 5,
    parameter bit DESCENDING = 1'b1
) (
    input  logic                clk,
    input  dpq_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    output dpq_pkg::word_t      head,
    output dpq_pkg::word_t      head_next
);
    import dpq_pkg::*;

    word_t words [CAPACITY];
    word_t nexts [CAPACITY];
    logic  keeps [CAPACITY];

    // Chain the cells, each seeing its neighbours; the ends see the new entry and their own word
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t left_w;
        word_t right_w;
        logic  left_k;

        if (i == 0)
        begin : g_first
            assign left_w = ctrl.new_word;
            assign left_k = 1'b0;
        end
        else
        begin : g_mid
            assign left_w = words[i-1];
            assign left_k = keeps[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = words[i];
        end
        else
        begin : g_inner
            assign right_w = words[i+1];
        end

        dpq_cell #(
            .IDX        (i),
            .CNT_W      (CNT_W),
            .DESCENDING (DESCENDING)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count),
            .left_word  (left_w),
            .left_keep  (left_k),
            .right_word (right_w),
            .word       (words[i]),
            .word_next  (nexts[i]),
            .keep       (keeps[i])
        );
    end

    assign head      = words[0];
    assign head_next = nexts[0];

endmodule
